>>> design/sactc_pkg.sv
// Shared types and constants for the set-associative cache tag controller.
// Holds the configuration register layout and register index codes.
// No dependencies.
package sactc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BLOCK_BITS   = 2'd0;
  localparam logic [1:0] REG_SET_BITS     = 2'd1;
  localparam logic [1:0] REG_WAY_BITS     = 2'd2;
  localparam logic [1:0] REG_REPLACE_FIFO = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int WAY_OUT_W   = 3;

  // Reset values of the configuration registers
  localparam logic [3:0] BLOCK_BITS_RST = 4'd5;
  localparam logic [2:0] SET_BITS_RST   = 3'd6;
  localparam logic [1:0] WAY_BITS_RST   = 2'd3;

  typedef struct packed {
    logic [3:0] block_bits;
    logic [2:0] set_bits;
    logic [1:0] way_bits;
    logic       replace_fifo;
  } cfg_t;

endpackage

>>> design/set_assoc_cache_tag_controller_unit.sv
// Top level of the set-associative cache tag controller.
// Holds configuration registers and joins front and back ends.
// Depends on sactc_pkg, sactc_front, sactc_back.
//
// Usage: raise start with is_write and address while busy is low; the
// access is taken at that edge. Each access yields one result: hit,
// write_back and way_used are valid in the single cycle that done is high,
// and the receiver must take it then. Results come out in access order.
// A two-entry queue sits between the front end (address split) and the
// back end (set read-modify-write), so busy rises only when it is full.
// With the queue empty, the back end pops the access and reads its set
// row, then in its execute state writes the row back and registers the
// result with done. The next access starts once the last leaves execute,
// set by the read-then-write of the set row on the single-port row memory.
// Configuration: write wr_data to register wr_index while wr_en is high;
// only while no access is in flight.
// Reset: clears configuration to its defaults, the queue, and the per-set
// row-valid flags, so every set reads as empty; no clearing pass is needed.
module set_assoc_cache_tag_controller_unit import sactc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAY_BITS = 3,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   start,
  output logic                   busy,
  input  logic                   is_write,
  input  logic [ADDR_WIDTH-1:0]  address,
  output logic                   done,
  output logic                   hit,
  output logic                   write_back,
  output logic [WAY_OUT_W-1:0]   way_used
);

  localparam int SIDX = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  cfg_t                  cfg;
  logic                  q_valid;
  logic                  q_pop;
  logic                  q_is_write;
  logic [SIDX-1:0]       q_set;
  logic [ADDR_WIDTH-1:0] q_tag;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_bits   <= BLOCK_BITS_RST;
      cfg.set_bits     <= SET_BITS_RST;
      cfg.way_bits     <= WAY_BITS_RST;
      cfg.replace_fifo <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BLOCK_BITS:   cfg.block_bits   <= wr_data[3:0];
        REG_SET_BITS:     cfg.set_bits     <= wr_data[2:0];
        REG_WAY_BITS:     cfg.way_bits     <= wr_data[1:0];
        REG_REPLACE_FIFO: cfg.replace_fifo <= wr_data[0];
        default: ;
      endcase
    end
  end

  sactc_front #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .is_write  (is_write),
    .address   (address),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_is_write(q_is_write),
    .q_set     (q_set),
    .q_tag     (q_tag)
  );

  sactc_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAY_BITS(MAX_WAY_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_is_write(q_is_write),
    .q_set     (q_set),
    .q_tag     (q_tag),
    .done      (done),
    .hit       (hit),
    .write_back(write_back),
    .way_used  (way_used)
  );

endmodule

>>> design/sactc_front.sv
// Front end of the cache tag controller: accepts accesses, splits the
// address into set index and tag, and queues them for the back end.
// Depends on sactc_pkg.
module sactc_front import sactc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  start,
  output logic                  busy,
  input  logic                  is_write,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic                  q_is_write,
  output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] q_set,
  output logic [ADDR_WIDTH-1:0] q_tag
);

  localparam int SIDX = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int IW   = 1 + SIDX + ADDR_WIDTH;

  logic [IW-1:0]         entry [2];
  logic                  wp;
  logic                  rp;
  logic [1:0]            count;
  logic                  push;
  logic [3:0]            sb;
  logic [4:0]            tag_shift;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [SIDX-1:0]       smask;
  logic [SIDX-1:0]       set_idx;
  logic [ADDR_WIDTH-1:0] tag;

  // Split the address under the current geometry
  always_comb begin
    sb        = (int'(cfg.set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(cfg.set_bits);
    tag_shift = 5'(cfg.block_bits) + 5'(sb);
    shifted   = address >> cfg.block_bits;
    smask     = SIDX'((32'd1 << sb) - 32'd1);
    set_idx   = SIDX'(shifted) & smask;
    tag       = address >> tag_shift;
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign {q_is_write, q_set, q_tag} = entry[rp];

  // Store the transaction in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= {is_write, set_idx, tag};
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !q_pop) |=> busy)
    else $error("full queue drained without a pop");

endmodule

>>> design/sactc_back.sv
// Back end of the cache tag controller: reads a set row, resolves hit,
// fill or eviction, writes the row back and issues the result.
// Depends on sactc_pkg.
module sactc_back import sactc_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAY_BITS = 3,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic                  q_is_write,
  input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] q_set,
  input  logic [ADDR_WIDTH-1:0] q_tag,
  output logic                  done,
  output logic                  hit,
  output logic                  write_back,
  output logic [WAY_OUT_W-1:0]  way_used
);

  localparam int SIDX  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int NW    = 1 << MAX_WAY_BITS;
  localparam int RW    = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;
  localparam int FCW   = MAX_WAY_BITS + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  typedef struct packed {
    logic [NW-1:0][ADDR_WIDTH-1:0] tag;
    logic [NW-1:0]                 dirty;
    logic [NW-1:0][RW-1:0]         rank;
    logic [FCW-1:0]                fc;
    logic [RW-1:0]                 head;
  } row_t;

  row_t                  mem [NSETS];
  logic [NSETS-1:0]      row_valid;
  logic                  state;
  row_t                  rd_row;
  logic                  rd_valid;
  logic                  cur_write;
  logic [SIDX-1:0]       cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;

  row_t                  nxt;
  logic [FCW-1:0]        fc;
  logic [RW-1:0]         head;
  logic [FCW-1:0]        ways;
  logic [RW-1:0]         wmask;
  logic [FCW-1:0]        nvalid;
  logic                  found;
  logic [RW-1:0]         hw;
  logic [RW-1:0]         victim;
  logic [RW-1:0]         r;
  logic [RW-1:0]         mn;
  logic                  wbk;
  logic [1:0]            wb_eff;

  assign q_pop = (state == ST_IDLE) && q_valid;

  // Resolve the access against the row read last cycle
  always_comb begin
    nxt    = rd_row;
    fc     = rd_valid ? rd_row.fc : '0;
    head   = rd_valid ? rd_row.head : '0;
    nxt.fc   = fc;
    nxt.head = head;
    wb_eff = (int'(cfg.way_bits) > MAX_WAY_BITS) ? 2'(MAX_WAY_BITS) : cfg.way_bits;
    ways   = FCW'(1) << wb_eff;
    wmask  = RW'(ways - FCW'(1));
    nvalid = (fc < ways) ? fc : ways;
    found  = 1'b0;
    hw     = '0;
    victim = '0;
    r      = '0;
    mn     = '1;
    wbk    = 1'b0;
    for (int w = 0; w < NW; w++) begin
      if (!found && (FCW'(w) < nvalid) && (rd_row.tag[w] == cur_tag)) begin
        found = 1'b1;
        hw    = RW'(w);
      end
    end
    if (found) begin
      // Hit: promote the way to most recent among filled ways
      r = rd_row.rank[hw];
      for (int j = 0; j < NW; j++) begin
        if ((FCW'(j) < ways) && (rd_row.rank[j] > r)) nxt.rank[j] = rd_row.rank[j] - RW'(1);
      end
      nxt.rank[hw] = (nvalid != '0) ? RW'(nvalid - FCW'(1)) : '0;
      if (cur_write) nxt.dirty[hw] = 1'b1;
      victim = hw;
    end else if (fc < ways) begin
      // Miss with a free way: fill the next way in order
      victim = RW'(fc);
      nxt.rank[victim] = (fc < ways - FCW'(1)) ? RW'(fc) : RW'(ways - FCW'(1));
      nxt.fc = fc + FCW'(1);
      nxt.tag[victim]   = cur_tag;
      nxt.dirty[victim] = cur_write;
    end else begin
      // Miss in a full set: pick a victim and evict
      if (cfg.replace_fifo) begin
        victim   = head & wmask;
        nxt.head = (victim + RW'(1)) & wmask;
      end else begin
        for (int w = 0; w < NW; w++) begin
          if ((FCW'(w) < ways) && (rd_row.rank[w] <= mn)) begin
            mn     = rd_row.rank[w];
            victim = RW'(w);
          end
        end
      end
      r = rd_row.rank[victim];
      for (int j = 0; j < NW; j++) begin
        if ((FCW'(j) < ways) && (RW'(j) != victim) && (rd_row.rank[j] > r))
          nxt.rank[j] = rd_row.rank[j] - RW'(1);
      end
      nxt.rank[victim]  = RW'(ways - FCW'(1));
      wbk               = rd_row.dirty[victim];
      nxt.tag[victim]   = cur_tag;
      nxt.dirty[victim] = cur_write;
    end
  end

  // Read the set row and latch the transaction
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_row    <= mem[q_set];
      rd_valid  <= row_valid[q_set];
      cur_write <= q_is_write;
      cur_set   <= q_set;
      cur_tag   <= q_tag;
    end
  end

  // Write the updated row back
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      mem[cur_set] <= nxt;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      hit        <= found;
      write_back <= wbk;
      way_used   <= WAY_OUT_W'({{WAY_OUT_W{1'b0}}, victim});
    end
  end

  // Sequence the read-modify-write and track written rows
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      row_valid <= '0;
    end else begin
      done <= (state == ST_EXEC);
      unique case (state)
        ST_IDLE: if (q_valid) state <= ST_EXEC;
        ST_EXEC: begin
          state              <= ST_IDLE;
          row_valid[cur_set] <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_spaced: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results closer than two cycles");
  a_pop_exec: assert property (@(posedge clk) disable iff (rst) q_pop |=> state == ST_EXEC)
    else $error("pop without execute");
  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst) done |-> !(hit && write_back))
    else $error("write-back on a hit");

endmodule

>>> tb/sv/sactc_checker.sv
// Checker for the set-associative cache tag controller: tracks register
// writes and accepted accesses, predicts each result and compares it.
// Depends on sactc_pkg.
module sactc_checker import sactc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   is_write,
  input  logic [63:0]            address,
  input  logic                   done,
  input  logic                   hit,
  input  logic                   write_back,
  input  logic [WAY_OUT_W-1:0]   way_used,
  output int                     errors,
  output int                     outstanding
);

  localparam int SETS_MAX = 64;
  localparam int WAYS_MAX = 8;

  typedef struct packed {
    logic       hit;
    logic       write_back;
    logic [2:0] way;
  } lookup_t;

  // Model copy of the tag arrays and replacement state
  logic [63:0] tag_mem [SETS_MAX*WAYS_MAX];
  logic        valid_mem [SETS_MAX*WAYS_MAX];
  logic        dirty_mem [SETS_MAX*WAYS_MAX];
  logic [2:0]  rank_mem [SETS_MAX*WAYS_MAX];
  logic [3:0]  fill_cnt [SETS_MAX];
  logic [2:0]  fifo_ptr [SETS_MAX];
  cfg_t        cfg;
  lookup_t     pending_lookups[$];

  // Predict one access and update the model state
  task automatic lookup_access(input logic wr, input logic [63:0] addr, output lookup_t res);
    int sb, wb, ways, set_idx, base, fc, cap, victim;
    logic [63:0] tag;
    logic [2:0] r, mn;
    logic found_free;
    sb = (cfg.set_bits > 6) ? 6 : cfg.set_bits;
    wb = cfg.way_bits;
    ways = 1 << wb;
    set_idx = int'((addr >> cfg.block_bits) & ((64'd1 << sb) - 1));
    tag = addr >> (cfg.block_bits + sb);
    base = set_idx * WAYS_MAX;
    fc = fill_cnt[set_idx];
    found_free = 1'b0;
    victim = 0;
    res = '0;
    for (int w = 0; w < ways; w++) begin
      if (!valid_mem[base+w]) begin
        victim = w;
        found_free = 1'b1;
        break;
      end
      if (tag_mem[base+w] == tag) begin
        r = rank_mem[base+w];
        cap = (fc < ways) ? fc : ways;
        for (int j = 0; j < ways; j++)
          if (rank_mem[base+j] > r) rank_mem[base+j] = 3'(rank_mem[base+j] - 3'd1);
        rank_mem[base+w] = (cap != 0) ? 3'(cap - 1) : 3'd0;
        if (wr) dirty_mem[base+w] = 1'b1;
        res.hit = 1'b1;
        res.way = 3'(w);
        return;
      end
    end
    if (found_free) begin
      rank_mem[base+victim] = 3'((fc < ways - 1) ? fc : ways - 1);
      if (fc < WAYS_MAX) fill_cnt[set_idx] = 4'(fc + 1);
      valid_mem[base+victim] = 1'b1;
    end else begin
      if (cfg.replace_fifo) begin
        victim = fifo_ptr[set_idx] & (ways - 1);
        fifo_ptr[set_idx] = 3'((victim + 1) & (ways - 1));
      end else begin
        mn = 3'd7;
        victim = 0;
        for (int w = 0; w < ways; w++)
          if (rank_mem[base+w] <= mn) begin
            mn = rank_mem[base+w];
            victim = w;
          end
      end
      r = rank_mem[base+victim];
      for (int w = 0; w < ways; w++)
        if (w != victim && rank_mem[base+w] > r)
          rank_mem[base+w] = 3'(rank_mem[base+w] - 3'd1);
      rank_mem[base+victim] = 3'(ways - 1);
      res.write_back = dirty_mem[base+victim];
    end
    tag_mem[base+victim] = tag;
    dirty_mem[base+victim] = wr;
    res.way = 3'(victim);
  endtask

  // Track writes, predict on each accepted transaction, compare each result
  always @(posedge clk) begin
    lookup_t exp_res;
    if (rst) begin
      cfg <= '{block_bits: BLOCK_BITS_RST, set_bits: SET_BITS_RST,
               way_bits: WAY_BITS_RST, replace_fifo: 1'b0};
      for (int i = 0; i < SETS_MAX*WAYS_MAX; i++) begin
        valid_mem[i] = 1'b0;
        dirty_mem[i] = 1'b0;
        rank_mem[i] = '0;
      end
      for (int i = 0; i < SETS_MAX; i++) begin
        fill_cnt[i] = '0;
        fifo_ptr[i] = '0;
      end
      pending_lookups.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (done) begin
        if (pending_lookups.size() == 0) begin
          if (errors < 10) $display("unexpected result hit=%0b wb=%0b way=%0d",
                                    hit, write_back, way_used);
          errors <= errors + 1;
        end else begin
          exp_res = pending_lookups.pop_front();
          if (hit !== exp_res.hit || write_back !== exp_res.write_back ||
              way_used !== exp_res.way) begin
            if (errors < 10)
              $display("mismatch: expected hit=%0b wb=%0b way=%0d, got hit=%0b wb=%0b way=%0d",
                       exp_res.hit, exp_res.write_back, exp_res.way,
                       hit, write_back, way_used);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        lookup_access(is_write, address, exp_res);
        pending_lookups.push_back(exp_res);
      end
      outstanding <= pending_lookups.size();
      if (wr_en) begin
        case (wr_index)
          REG_BLOCK_BITS:   cfg.block_bits <= wr_data[3:0];
          REG_SET_BITS:     cfg.set_bits <= wr_data[2:0];
          REG_WAY_BITS:     cfg.way_bits <= wr_data[1:0];
          REG_REPLACE_FIFO: cfg.replace_fifo <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/sv/tb_set_assoc_cache_tag_controller_unit.sv
// Testbench top for the set-associative cache tag controller: drives
// register writes and read/write accesses, gives the verdict.
// Depends on sactc_pkg, set_assoc_cache_tag_controller_unit, sactc_checker.
module tb_set_assoc_cache_tag_controller_unit;
  import sactc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic start = 1'b0;
  logic is_write = 1'b0;
  logic [63:0] address = '0;
  logic busy, done, hit, write_back;
  logic [WAY_OUT_W-1:0] way_used;
  int errors, outstanding;
  int cycle_cnt = 0;
  int cur_block = 5;
  int cur_set = 6;
  bit no_idle = 1'b0;

  set_assoc_cache_tag_controller_unit u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .is_write(is_write), .address(address),
    .done(done), .hit(hit), .write_back(write_back), .way_used(way_used)
  );

  sactc_checker u_checker (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .is_write(is_write), .address(address),
    .done(done), .hit(hit), .write_back(write_back), .way_used(way_used),
    .errors(errors), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_access(input logic wr, input logic [63:0] addr);
    @(negedge clk);
    start <= 1'b1;
    is_write <= wr;
    address <= addr;
    do @(posedge clk); while (busy);
    if (!no_idle && $urandom_range(99) < 37) begin
      @(negedge clk);
      start <= 1'b0;
      is_write <= 1'($urandom_range(1));
      address <= {$urandom, $urandom};
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  // Drop start, then wait until every result has come plus settle time
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_DATA_W'(val);
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_BLOCK_BITS) cur_block = val & 15;
    if (idx == REG_SET_BITS) cur_set = ((val & 7) > 6) ? 6 : (val & 7);
  endtask

  task automatic configure(input int bb, input int sb, input int wb, input int fifo);
    drain();
    write_reg(REG_BLOCK_BITS, bb);
    write_reg(REG_SET_BITS, sb);
    write_reg(REG_WAY_BITS, wb);
    write_reg(REG_REPLACE_FIFO, fifo);
  endtask

  // Build an address from a small tag pool and few sets so hits and evictions occur
  function automatic logic [63:0] pick_address();
    logic [63:0] tag, set_idx, off;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return {$urandom, $urandom};
    tag = (sel < 14) ? {$urandom, $urandom} : 64'($urandom_range(11));
    set_idx = 64'($urandom_range(3)) & ((64'd1 << cur_set) - 1);
    off = {$urandom, $urandom} & ((64'd1 << cur_block) - 1);
    return (tag << (cur_block + cur_set)) | (set_idx << cur_block) | off;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_access(1'($urandom_range(1)), pick_address());
      if (i == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill one set past its eight ways with writes, hit, then evict dirty lines
    for (int t = 0; t < 9; t++) send_access(1'b1, 64'(t) << 11);
    send_access(1'b0, 64'd2 << 11);
    send_access(1'b1, 64'd9 << 11);
    send_access(1'b0, 64'd0);
    send_access(1'b1, '1);
    send_access(1'b0, '1);
    send_access(1'b0, 64'h8000_0000_0000_0000);
    drain();

    // FIFO pointer with a full set, tiny geometry, and oversized set count
    configure(0, 0, 1, 1);
    for (int t = 0; t < 6; t++) send_access(t[0], 64'(t % 3));
    configure(12, 7, 3, 1);
    send_access(1'b1, '1);
    send_access(1'b0, '1);

    no_idle = 1'b1;
    random_phase(150);
    no_idle = 1'b0;
    configure(5, 2, 2, 0);
    random_phase(150);
    configure(0, 0, 0, 0);
    random_phase(120);
    configure(3, 6, 3, 1);
    random_phase(150);
    configure(12, 0, 3, 0);
    random_phase(150);
    // Switch policy mid-use with state kept
    configure(12, 0, 3, 1);
    random_phase(150);
    configure(7, 3, 1, 1);
    random_phase(150);
    configure(5, 6, 3, 0);
    random_phase(150);

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
